// ===== sv/jos_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Josephus survivor package
// Shared widths, default limits and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package jos_pkg;

  localparam int CNT_W  = 9;
  localparam int STEP_W = 10;
  localparam int K_W    = CNT_W + 1;
  localparam int SUM_W  = $clog2((1 << CNT_W) + (1 << STEP_W) - 1);
  localparam int BIT_W  = $clog2(SUM_W);

  localparam int MAX_SOLDIERS_DEF = 256;
  localparam int MAX_STEP_DEF     = 1023;

  typedef struct packed {
    logic load;
    logic mod_init;
    logic mod_step;
    logic commit;
    logic finish;
  } jos_cmd_t;

  typedef struct packed {
    logic k_gt_n;
    logic bit_last;
  } jos_stat_t;

endpackage

// ===== sv/jos_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Josephus survivor datapath
// Holds the request, the running offset and the circle size, a bit-serial
// remainder unit and the result register.
// ----------------------------------------------------------------------------
module jos_dp #(
  parameter int MAX_SOLDIERS = jos_pkg::MAX_SOLDIERS_DEF,
  parameter int MAX_STEP     = jos_pkg::MAX_STEP_DEF
) (
  input  logic                      clk,
  input  logic [jos_pkg::CNT_W-1:0]  in_soldier_count,
  input  logic [jos_pkg::STEP_W-1:0] in_step_count,
  input  logic                      in_clockwise,
  input  jos_pkg::jos_cmd_t          cmd,
  output jos_pkg::jos_stat_t         stat,
  output logic [jos_pkg::CNT_W-1:0]  label
);

  logic [jos_pkg::CNT_W-1:0]  n_r;
  logic [jos_pkg::STEP_W-1:0] m_r;
  logic                       cw_r;
  logic [jos_pkg::CNT_W-1:0]  f_r;
  logic [jos_pkg::K_W-1:0]    k_r;
  logic [jos_pkg::CNT_W-1:0]  rem_r;
  logic [jos_pkg::SUM_W-1:0]  div_r;
  logic [jos_pkg::BIT_W-1:0]  bcnt_r;
  logic [jos_pkg::CNT_W-1:0]  label_r;

  logic [jos_pkg::CNT_W-1:0]  n_nxt;
  logic [jos_pkg::STEP_W-1:0] m_nxt;
  logic [jos_pkg::K_W-1:0]    r_sh;
  logic [jos_pkg::CNT_W-1:0]  rem_nxt;
  logic [jos_pkg::CNT_W-1:0]  label_nxt;

  always_comb begin
    if (32'(in_soldier_count) > 32'(MAX_SOLDIERS)) begin
      n_nxt = jos_pkg::CNT_W'(MAX_SOLDIERS);
    end else begin
      n_nxt = in_soldier_count;
    end
    if (32'(in_step_count) > 32'(MAX_STEP)) begin
      m_nxt = jos_pkg::STEP_W'(MAX_STEP);
    end else if (in_step_count == '0) begin
      m_nxt = jos_pkg::STEP_W'(1);
    end else begin
      m_nxt = in_step_count;
    end
  end

  assign r_sh = {rem_r, div_r[jos_pkg::SUM_W-1]};

  always_comb begin
    if (r_sh >= k_r) begin
      rem_nxt = jos_pkg::CNT_W'(r_sh - k_r);
    end else begin
      rem_nxt = jos_pkg::CNT_W'(r_sh);
    end
  end

  always_comb begin
    if (n_r == '0) begin
      label_nxt = '0;
    end else if (cw_r || f_r == '0) begin
      label_nxt = f_r + jos_pkg::CNT_W'(1);
    end else begin
      label_nxt = n_r - f_r + jos_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r  <= n_nxt;
      m_r  <= m_nxt;
      cw_r <= in_clockwise;
      f_r  <= '0;
      k_r  <= jos_pkg::K_W'(2);
    end
    if (cmd.mod_init) begin
      div_r  <= jos_pkg::SUM_W'(f_r) + jos_pkg::SUM_W'(m_r);
      rem_r  <= '0;
      bcnt_r <= '0;
    end else if (cmd.mod_step) begin
      div_r  <= {div_r[jos_pkg::SUM_W-2:0], 1'b0};
      rem_r  <= rem_nxt;
      bcnt_r <= bcnt_r + jos_pkg::BIT_W'(1);
    end
    if (cmd.commit) begin
      f_r <= rem_r;
      k_r <= k_r + jos_pkg::K_W'(1);
    end
    if (cmd.finish) begin
      label_r <= label_nxt;
    end
  end

  assign stat.k_gt_n   = k_r > jos_pkg::K_W'(n_r);
  assign stat.bit_last = bcnt_r == jos_pkg::BIT_W'(jos_pkg::SUM_W - 1);
  assign label         = label_r;

endmodule

// ===== sv/jos_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Josephus survivor controller
// Sequences one request through the recurrence and owns both handshakes.
// ----------------------------------------------------------------------------
module jos_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output jos_pkg::jos_cmd_t  cmd,
  input  jos_pkg::jos_stat_t stat
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TEST   = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    in_stall      = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (stat.k_gt_n) begin
          state_nxt = S_FIN;
        end else begin
          cmd.mod_init = 1'b1;
          state_nxt    = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.bit_last) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_TEST;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sv/josephus_survivor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Josephus survivor
// Returns the label of the last soldier left in Josephus elimination.
// ----------------------------------------------------------------------------
// A request carries the soldier count, the step and the direction on the in_
// ports and is taken when in_valid is high and in_stall is low. One request
// is worked on at a time; in_stall is low only while the block is idle.
// The survivor offset follows f(k) = (f(k-1) + m) mod k for k = 2..n, each
// step running a bit-serial remainder unit, with a test state before it that
// sets it up and a commit state after it. The next request can be taken in
// the first cycle that out_valid is high. The result sits in an output
// register under out_valid until it is taken with out_stall low. A new
// request is accepted while that result waits; if it finishes before the
// old result is taken, it holds until then. A synchronous reset clears
// the controller and drops out_valid.
// ----------------------------------------------------------------------------
module josephus_survivor #(
  parameter int MAX_SOLDIERS = jos_pkg::MAX_SOLDIERS_DEF,
  parameter int MAX_STEP     = jos_pkg::MAX_STEP_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [jos_pkg::CNT_W-1:0]  in_soldier_count,
  input  logic [jos_pkg::STEP_W-1:0] in_step_count,
  input  logic                       in_clockwise,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [jos_pkg::CNT_W-1:0]  out_survivor_label
);

  jos_pkg::jos_cmd_t  cmd;
  jos_pkg::jos_stat_t stat;

  jos_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  jos_dp #(
    .MAX_SOLDIERS (MAX_SOLDIERS),
    .MAX_STEP     (MAX_STEP)
  ) u_dp (
    .clk              (clk),
    .in_soldier_count (in_soldier_count),
    .in_step_count    (in_step_count),
    .in_clockwise     (in_clockwise),
    .cmd              (cmd),
    .stat             (stat),
    .label            (out_survivor_label)
  );

endmodule

// ===== tb/josephus_survivor_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Josephus survivor testbench
// Sends soldier count, step and direction requests to the block and checks
// each returned survivor label against a recurrence-based prediction held in
// a small tracker. Directed corner cases come first, then random requests
// under three idling mixes on the request and result sides.
// ----------------------------------------------------------------------------

class survivor_tracker;
  localparam int CW = jos_pkg::CNT_W;
  localparam int SW = jos_pkg::STEP_W;

  logic [CW-1:0] expected_labels[$];
  int unsigned   failures = 0;

  function automatic logic [CW-1:0] survivor_of(logic [CW-1:0] count_in,
                                                logic [SW-1:0] step_in,
                                                bit            ascending);
    int unsigned n;
    int unsigned m;
    int unsigned offset;
    int unsigned k;
    n = 32'(count_in);
    m = 32'(step_in);
    if (n > jos_pkg::MAX_SOLDIERS_DEF) n = jos_pkg::MAX_SOLDIERS_DEF;
    if (m > jos_pkg::MAX_STEP_DEF) m = jos_pkg::MAX_STEP_DEF;
    if (m == 0) m = 1;
    if (n == 0) return '0;
    offset = 0;
    for (k = 2; k <= n; k++) offset = (offset + m) % k;
    if (ascending) return CW'(offset + 1);
    return CW'(n - ((n - 1 + offset) % n));
  endfunction

  function void note_request(logic [CW-1:0] count_in, logic [SW-1:0] step_in,
                             bit ascending);
    expected_labels.push_back(survivor_of(count_in, step_in, ascending));
  endfunction

  function void check_label(logic [CW-1:0] got);
    logic [CW-1:0] want;
    if (expected_labels.size() == 0) begin
      $display("%0t: survivor_label with no request waiting, expected none, actual %0d",
               $time, got);
      failures++;
      return;
    end
    want = expected_labels.pop_front();
    if (got !== want) begin
      $display("%0t: survivor_label mismatch, expected %0d, actual %0d", $time, want, got);
      failures++;
    end
  endfunction

  function int unsigned pending();
    return expected_labels.size();
  endfunction
endclass

module josephus_survivor_tb;
  localparam int          CW          = jos_pkg::CNT_W;
  localparam int          SW          = jos_pkg::STEP_W;
  localparam int          PHASE_ITEMS = 510;
  localparam int          SETTLE      = 3500;
  localparam int unsigned CYCLE_LIMIT = 40_000_000;

  logic          clk                = 1'b0;
  logic          rst_n              = 1'b0;
  logic          in_valid           = 1'b0;
  logic          in_stall;
  logic [CW-1:0] in_soldier_count   = '0;
  logic [SW-1:0] in_step_count      = '0;
  logic          in_clockwise       = 1'b0;
  logic          out_valid;
  logic          out_stall          = 1'b0;
  logic [CW-1:0] out_survivor_label;

  int unsigned     send_idle_pct  = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     cycles         = 0;
  survivor_tracker board;

  josephus_survivor dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_soldier_count   (in_soldier_count),
    .in_step_count      (in_step_count),
    .in_clockwise       (in_clockwise),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_survivor_label (out_survivor_label)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) board.check_label(out_survivor_label);
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_request(input logic [CW-1:0] count_in, input logic [SW-1:0] step_in,
                              input bit ascending);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_soldier_count <= count_in;
    in_step_count    <= step_in;
    in_clockwise     <= ascending;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    board.note_request(count_in, step_in, ascending);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random_request();
    int unsigned   pick;
    logic [CW-1:0] count_in;
    logic [SW-1:0] step_in;
    pick = $urandom_range(99);
    if (pick < 2) count_in = CW'($urandom_range(511, 256));
    else if (pick < 7) count_in = CW'($urandom_range(255, 41));
    else count_in = CW'($urandom_range(40, 0));
    pick = $urandom_range(99);
    if (pick < 5) step_in = '0;
    else if (pick < 10) step_in = SW'(1);
    else if (pick < 14) step_in = '1;
    else if (pick < 40) step_in = SW'($urandom_range(12, 2));
    else step_in = SW'($urandom);
    send_request(count_in, step_in, 1'($urandom_range(1)));
  endtask

  initial begin
    board = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(9'd0,   10'd3,    1'b1);
    send_request(9'd0,   10'd1023, 1'b0);
    send_request(9'd1,   10'd0,    1'b1);
    send_request(9'd1,   10'd5,    1'b0);
    send_request(9'd2,   10'd1,    1'b1);
    send_request(9'd2,   10'd1,    1'b0);
    send_request(9'd7,   10'd0,    1'b1);
    send_request(9'd7,   10'd0,    1'b0);
    send_request(9'd7,   10'd3,    1'b1);
    send_request(9'd7,   10'd3,    1'b0);
    send_request(9'd41,  10'd3,    1'b1);
    send_request(9'd10,  10'd1023, 1'b1);
    send_request(9'd10,  10'd1023, 1'b0);
    send_request(9'd10,  10'd512,  1'b0);
    send_request(9'd255, 10'd2,    1'b1);
    send_request(9'd256, 10'd1023, 1'b1);
    send_request(9'd256, 10'd0,    1'b0);
    send_request(9'd257, 10'd7,    1'b1);
    send_request(9'd511, 10'd1,    1'b0);
    send_request(9'd3,   10'd2,    1'b0);
    drain_results();

    send_idle_pct  = 35;
    recv_stall_pct = 54;
    repeat (PHASE_ITEMS) send_random_request();
    drain_results();

    send_idle_pct  = 54;
    recv_stall_pct = 35;
    repeat (PHASE_ITEMS) send_random_request();
    drain_results();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (PHASE_ITEMS) send_random_request();
    drain_results();

    repeat (SETTLE) @(posedge clk);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
